@@ hw/rtl/cspd_pkg.sv @@
// Shared types and fixed constants of the cloud shadow pixel dimmer.
// No dependencies; cspd_noise, cspd_mix and the core import this package.
package cspd_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DENSITY = 2'd0;
    localparam logic [1:0] CFG_DAY     = 2'd1;
    localparam logic [1:0] CFG_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_HEIGHT  = 2'd3;

    // Coordinate hash multipliers.
    localparam logic [31:0] HASH_C1 = 32'd73856093;
    localparam logic [31:0] HASH_C2 = 32'd19349663;
    localparam logic [31:0] HASH_C3 = 32'd1274126177;

    // The 12-bit noise value is scaled by ONE / 40950 through a reciprocal.
    localparam int unsigned NOISE_DIV    = 40950;
    localparam int unsigned RECIP_SHIFT  = 13;

    typedef struct packed {
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // Channels and the pass-through flag as they travel down the pipeline.
    typedef struct packed {
        logic       pass;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } lane_t;

endpackage

@@ hw/rtl/cspd_delay.sv @@
// Enabled shift line that carries a payload a fixed number of stages.
// No dependencies.
module cspd_delay #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= d;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[DEPTH-1];

endmodule

@@ hw/rtl/cspd_noise.sv @@
// Coordinate hash and signed noise offset, five register stages.
// Depends on cspd_pkg for the hash constants and the noise scaling.
module cspd_noise #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [15:0]                 col,
    input  logic [15:0]                 row,
    output logic signed [FRAC_BITS-2:0] noise_mod
);
    import cspd_pkg::*;

    localparam int CB   = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int MW   = FRAC_BITS - 2;
    localparam int TW   = 12 + MW;
    localparam int QW   = TW - RECIP_SHIFT;
    localparam int RW   = FRAC_BITS + 13;
    localparam int MODW = FRAC_BITS - 1;
    localparam longint unsigned ONE_L = 64'd1 << FRAC_BITS;
    localparam logic [MW-1:0] RECIP =
        MW'((64'd1 << (FRAC_BITS + RECIP_SHIFT)) / NOISE_DIV);
    localparam logic [MODW-1:0] C5 = MODW'((ONE_L * 5 + 50) / 100);

    logic [31:0]     xm, ym, hx, hy;
    logic [24:0]     h_reg;
    logic [11:0]     g;
    logic [23:0]     np;
    logic [11:0]     n3_reg, n4_reg, n5_reg;
    logic [TW-1:0]   t_reg;
    logic [QW-1:0]   q0;
    logic [QW-1:0]   q0_reg;
    logic [RW-1:0]   p_reg;
    logic [RW-1:0]   r;
    logic [MODW-1:0] q_fix;
    logic [MODW-1:0] mod_reg;

    always_comb
    begin
        xm = 32'(col[CB-1:0]);
        ym = 32'(row[CB-1:0]);
        hx = xm * HASH_C1;
        hy = ym * HASH_C2;
        // Only the low twelve bits of the final hash are used, so the
        // xor-shift needs the low 25 bits of the first hash alone.
        g  = h_reg[11:0] ^ h_reg[24:13];
        np = 24'(g) * 24'(HASH_C3[11:0]);
        q0 = t_reg[TW-1:RECIP_SHIFT];
        // The reciprocal estimate is low by at most one.
        r     = RW'({n5_reg, {FRAC_BITS{1'b0}}}) - p_reg;
        q_fix = MODW'(q0_reg) + ((r >= RW'(NOISE_DIV)) ? MODW'(1) : MODW'(0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg   <= hx[24:0] ^ hy[24:0];
            n3_reg  <= np[11:0];
            t_reg   <= TW'(n3_reg) * TW'(RECIP);
            n4_reg  <= n3_reg;
            q0_reg  <= q0;
            p_reg   <= RW'(q0) * RW'(NOISE_DIV);
            n5_reg  <= n4_reg;
            mod_reg <= q_fix - C5;
        end
    end

    assign noise_mod = $signed(mod_reg);

endmodule

@@ hw/rtl/cspd_alt_div.sv @@
// Altitude factor ONE - row * ONE / (5 * height) from a restoring divider
// with one quotient bit per stage. Depends on nothing outside this file.
module cspd_alt_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [15:0]        row_clamp,
    input  logic [15:0]        height,
    output logic [FRAC_BITS:0] alt
);

    // The row is clamped to the height, so the quotient stays below ONE / 4.
    localparam int QB = FRAC_BITS - 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(64'd1 << FRAC_BITS);

    logic [18:0]        divisor;
    logic [18:0]        rem_reg [QB];
    logic [QB-1:0]      q_reg   [QB];
    logic [FRAC_BITS:0] alt_reg;

    assign divisor = 19'({height, 2'b00}) + 19'(height);

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [18:0]   rem_in;
        logic [QB-1:0] q_in;
        logic [19:0]   sh;
        logic          ge;
        logic [18:0]   rem_next;
        logic [QB-1:0] q_next;

        if (k == 0)
        begin : g_first
            // The dividend is row * 2^FRAC_BITS: all bits brought down are zero.
            assign rem_in = {1'b0, row_clamp, 2'b00};
            assign q_in   = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        always_comb
        begin
            sh = {rem_in, 1'b0};
            ge = (sh >= {1'b0, divisor});
            rem_next = ge ? 19'(sh - {1'b0, divisor}) : sh[18:0];
            q_next = {q_in[QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                q_reg[k]   <= q_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg <= ONE - (FRAC_BITS+1)'(q_reg[QB-1]);
        end
    end

    assign alt = alt_reg;

endmodule

@@ hw/rtl/cspd_mix.sv @@
// Base dimming, noise weighting, clamping and the channel products in three
// register stages; the last one is the output register. Depends on cspd_pkg.
module cspd_mix #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [FRAC_BITS:0]          density,
    input  logic                        day_mode,
    input  logic [FRAC_BITS:0]          alt,
    input  logic signed [FRAC_BITS-2:0] noise_mod,
    input  cspd_pkg::lane_t             lane,
    output cspd_pkg::pix_out_t          dim
);
    import cspd_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int SW = F + 3;
    localparam int CW = F + 9;
    localparam longint unsigned ONE_L = 64'd1 << F;
    localparam logic [F:0] ONE = (F+1)'(ONE_L);
    localparam logic [F:0] C3  = (F+1)'((ONE_L * 3 + 50) / 100);
    localparam logic [F:0] C5  = (F+1)'((ONE_L * 5 + 50) / 100);
    localparam logic [F:0] C25 = (F+1)'((ONE_L * 25 + 50) / 100);
    localparam logic [F:0] C65 = (F+1)'((ONE_L * 65 + 50) / 100);
    localparam logic [F:0] C85 = (F+1)'((ONE_L * 85 + 50) / 100);
    localparam logic [F:0] C90 = (F+1)'((ONE_L * 90 + 50) / 100);

    logic [F-2:0]  mabs;
    logic [2*F-1:0] mprod;
    logic [F:0]    fac, floor_v, bp, braw, base_next;
    logic [2*F:0]  bprod;
    logic [F-1:0]  mag_reg;
    logic          neg_reg;
    logic [F:0]    base_reg;
    lane_t         lane1_reg, lane2_reg;
    logic signed [SW-1:0] p;
    logic [F:0]    pix_next, pix_reg;
    logic [CW-1:0] pr, pg, pb;
    pix_out_t      dim_next, dim_reg;

    always_comb
    begin
        mabs  = noise_mod[F-2] ? (~noise_mod + (F-1)'(1)) : noise_mod;
        mprod = (2*F)'(mabs) * (2*F)'(alt);

        fac     = day_mode ? C65 : C85;
        floor_v = (day_mode && density > C90) ? C5 : C25;
        bprod   = (2*F+1)'(density) * (2*F+1)'(fac);
        bp      = bprod[2*F:F];
        braw    = (bp >= ONE) ? '0 : ONE - bp;
        if (braw < floor_v)
        begin
            base_next = floor_v;
        end
        else if (braw > ONE)
        begin
            base_next = ONE;
        end
        else
        begin
            base_next = braw;
        end

        // Magnitude and sign were split, so the shift truncates toward zero.
        if (neg_reg)
        begin
            p = $signed(SW'(base_reg)) + $signed(SW'(mag_reg));
        end
        else
        begin
            p = $signed(SW'(base_reg)) - $signed(SW'(mag_reg));
        end
        if (p < $signed(SW'(C3)))
        begin
            pix_next = C3;
        end
        else if (p > $signed(SW'(ONE)))
        begin
            pix_next = ONE;
        end
        else
        begin
            pix_next = p[F:0];
        end

        pr = CW'(lane2_reg.red)   * CW'(pix_reg);
        pg = CW'(lane2_reg.green) * CW'(pix_reg);
        pb = CW'(lane2_reg.blue)  * CW'(pix_reg);
        if (lane2_reg.pass)
        begin
            dim_next.red_out   = lane2_reg.red;
            dim_next.green_out = lane2_reg.green;
            dim_next.blue_out  = lane2_reg.blue;
        end
        else
        begin
            dim_next.red_out   = pr[F+7:F];
            dim_next.green_out = pg[F+7:F];
            dim_next.blue_out  = pb[F+7:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg   <= mprod[2*F-1:F];
            neg_reg   <= noise_mod[F-2];
            base_reg  <= base_next;
            lane1_reg <= lane;
            pix_reg   <= pix_next;
            lane2_reg <= lane1_reg;
            dim_reg   <= dim_next;
        end
    end

    assign dim = dim_reg;

endmodule

@@ hw/rtl/cloud_shadow_pixel_dimmer_core.sv @@
// Top level of the cloud shadow pixel dimmer: configuration registers, input
// stage, valid chain and the pipeline. Depends on cspd_pkg and all cspd_ modules.

// The core dims one RGB pixel per clock while the output does not stall, as a
// cloud shadow would, from the cloud density, the day flag and a hash of the
// pixel's column and row, with an altitude weighting over the image height. A
// new pixel is taken in every cycle in which pix_stall is low; the altitude
// divider resolves one quotient bit per pipeline stage. A stall on the output
// while a result is held freezes the whole pipeline and is passed back on
// pix_stall in the same cycle. Configuration must be written through cfg_we,
// cfg_index and cfg_data while no pixel is in flight; the core does not check.
module cloud_shadow_pixel_dimmer_core #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [16:0]        cfg_data,
    input  logic               pix_valid,
    output logic               pix_stall,
    input  cspd_pkg::pix_in_t  pix,
    output logic               dim_valid,
    input  logic               dim_stall,
    output cspd_pkg::pix_out_t dim
);
    import cspd_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int LAT = F + 3;
    localparam int LW  = $bits(lane_t);
    localparam longint unsigned ONE_L = 64'd1 << F;
    localparam logic [F:0] ONE = (F+1)'(ONE_L);
    localparam logic [F:0] C4  = (F+1)'((ONE_L * 4 + 50) / 100);

    logic [16:0]   density_reg;
    logic          day_reg;
    logic [15:0]   width_reg;
    logic [15:0]   height_reg;
    logic [LAT-1:0] v_reg;
    logic          adv;
    logic [F+16:0] dens_wide;
    logic [F:0]    d_raw, d_sat;
    lane_t         lane_next, lane_reg;
    logic [15:0]   rowc_next;
    logic [15:0]   col_reg, row_reg, rowc_reg;
    logic [F:0]    alt;
    logic signed [F-2:0] mod_early, mod_late;
    logic [LW-1:0] lane_late;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            density_reg <= '0;
            day_reg     <= 1'b1;
            width_reg   <= '0;
            height_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DENSITY: density_reg <= cfg_data;
                CFG_DAY:     day_reg     <= cfg_data[0];
                CFG_WIDTH:   width_reg   <= cfg_data[15:0];
                CFG_HEIGHT:  height_reg  <= cfg_data[15:0];
                default:     density_reg <= density_reg;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being taken.
    assign adv       = !v_reg[LAT-1] || !dim_stall;
    assign pix_stall = !adv;
    assign dim_valid = v_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[LAT-2:0], pix_valid};
        end
    end

    always_comb
    begin
        dens_wide = {density_reg, {F{1'b0}}};
        d_raw     = dens_wide[F+16:16];
        d_sat     = (d_raw > ONE) ? ONE : d_raw;
        lane_next.pass  = (width_reg == 16'd0) || (height_reg == 16'd0) || (d_sat <= C4);
        lane_next.red   = pix.red_in;
        lane_next.green = pix.green_in;
        lane_next.blue  = pix.blue_in;
        rowc_next = (pix.row > height_reg) ? height_reg : pix.row;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lane_reg <= lane_next;
            col_reg  <= pix.col;
            row_reg  <= pix.row;
            rowc_reg <= rowc_next;
        end
    end

    cspd_noise #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_noise (
        .clk       (clk),
        .en        (adv),
        .col       (col_reg),
        .row       (row_reg),
        .noise_mod (mod_early)
    );

    cspd_delay #(
        .WIDTH (F - 1),
        .DEPTH (F - 6)
    ) u_mod_delay (
        .clk (clk),
        .en  (adv),
        .d   (mod_early),
        .q   (mod_late)
    );

    cspd_alt_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_alt_div (
        .clk       (clk),
        .en        (adv),
        .row_clamp (rowc_reg),
        .height    (height_reg),
        .alt       (alt)
    );

    cspd_delay #(
        .WIDTH (LW),
        .DEPTH (F - 1)
    ) u_lane_delay (
        .clk (clk),
        .en  (adv),
        .d   (lane_reg),
        .q   (lane_late)
    );

    cspd_mix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mix (
        .clk       (clk),
        .en        (adv),
        .density   (d_sat),
        .day_mode  (day_reg),
        .alt       (alt),
        .noise_mod (mod_late),
        .lane      (lane_t'(lane_late)),
        .dim       (dim)
    );

endmodule
